### rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg: shared types and constants of the challenge sampler
// Opcodes, status codes, command word passed from front to back, back
// end state encoding and the fixed sizes of the coefficient store.
// ----------------------------------------------------------------------------
package scs_pkg;

    // store geometry
    localparam int COEFF_COUNT = 256;
    localparam int IDX_W       = 8;
    localparam int POS_W       = 9;
    localparam int SIGN_BYTES  = 8;
    localparam int SIGN_W      = 64;
    localparam int CNT_W       = 4;
    localparam int WEIGHT_W    = 7;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 7'd60;

    // request opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // response status codes
    localparam logic [2:0] ST_STARTED = 3'd0;
    localparam logic [2:0] ST_SIGN    = 3'd1;
    localparam logic [2:0] ST_ACCEPT  = 3'd2;
    localparam logic [2:0] ST_REJECT  = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;
    localparam logic [2:0] ST_READ    = 3'd5;

    // stored coefficient codes
    localparam logic [1:0] COEFF_ZERO = 2'b00;
    localparam logic [1:0] COEFF_POS  = 2'b01;
    localparam logic [1:0] COEFF_NEG  = 2'b11;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_RESULT,
        CMD_SWAP,
        CMD_READ
    } cmd_kind_t;

    // one classified word from front to back
    typedef struct packed {
        cmd_kind_t        kind;
        logic [2:0]       status;
        logic             done;
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] pos;
        logic             sign;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SWAP,
        BK_READ
    } back_state_t;

endpackage

### rtl/scs_if.sv
// ----------------------------------------------------------------------------
// scs_if: handshake channels of the challenge sampler
// Request, response and weight write channels, each valid/ready with its
// payload, with a source and a sink modport.
// ----------------------------------------------------------------------------
interface scs_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] byte_value;
    logic [7:0] read_index;

    modport source (output valid, output opcode, output byte_value, output read_index,
                    input ready);
    modport sink   (input valid, input opcode, input byte_value, input read_index,
                    output ready);
endinterface

interface scs_rsp_if;
    logic              valid;
    logic              ready;
    logic        [2:0] status;
    logic signed [1:0] coefficient;
    logic              done_res;

    modport source (output valid, output status, output coefficient, output done_res,
                    input ready);
    modport sink   (input valid, input status, input coefficient, input done_res,
                    output ready);
endinterface

interface scs_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] weight;

    modport source (output valid, output weight, input ready);
    modport sink   (input valid, input weight, output ready);
endinterface

### rtl/scs_front.sv
// ----------------------------------------------------------------------------
// scs_front: request decoder and sampling counters
// Takes one request word a cycle while cmd_ready is high, keeps the weight,
// sign word, sign byte count, position and done flag; makes each a command.
// ----------------------------------------------------------------------------
module scs_front (
    input  logic          clk,
    input  logic          rst_n,
    scs_req_if.sink       req,
    scs_cfg_if.sink       cfg,
    output scs_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_ready
);
    import scs_pkg::*;

    logic [WEIGHT_W-1:0] weight_reg;
    logic [SIGN_W-1:0]   sign_word_reg, sign_word_next;
    logic [CNT_W-1:0]    sign_cnt_reg, sign_cnt_next;
    logic [POS_W-1:0]    position_reg, position_next;
    logic                finished_reg, finished_next;
    logic [POS_W-1:0]    pos_start;
    logic [POS_W-1:0]    pos_inc;
    logic                fire;

    assign cfg.ready = 1'b1;
    assign req.ready = cmd_ready;
    assign cmd_valid = req.valid;
    assign fire      = req.valid && cmd_ready;

    assign pos_start = POS_W'(COEFF_COUNT) - {{(POS_W-WEIGHT_W){1'b0}}, weight_reg};
    assign pos_inc   = position_reg + POS_W'(1);

    // classify and compute next counters
    always_comb
    begin
        sign_word_next = sign_word_reg;
        sign_cnt_next  = sign_cnt_reg;
        position_next  = position_reg;
        finished_next  = finished_reg;
        cmd.kind       = CMD_RESULT;
        cmd.status     = ST_IGNORED;
        cmd.addr       = req.read_index;
        cmd.pos        = position_reg[IDX_W-1:0];
        cmd.sign       = sign_word_reg[0];
        unique case (req.opcode)
            OP_START:
            begin
                cmd.kind       = CMD_START;
                cmd.status     = ST_STARTED;
                sign_word_next = '0;
                sign_cnt_next  = '0;
                position_next  = pos_start;
                finished_next  = (weight_reg == '0);
            end
            OP_BYTE:
            begin
                if (finished_reg)
                begin
                    cmd.status = ST_IGNORED;
                end
                else if (sign_cnt_reg < CNT_W'(SIGN_BYTES))
                begin
                    cmd.status = ST_SIGN;
                    sign_word_next[{sign_cnt_reg[2:0], 3'b000} +: 8] = req.byte_value;
                    sign_cnt_next  = sign_cnt_reg + CNT_W'(1);
                end
                else if ({1'b0, req.byte_value} > position_reg)
                begin
                    cmd.status = ST_REJECT;
                end
                else
                begin
                    cmd.kind       = CMD_SWAP;
                    cmd.status     = ST_ACCEPT;
                    cmd.addr       = req.byte_value;
                    sign_word_next = sign_word_reg >> 1;
                    position_next  = pos_inc;
                    finished_next  = pos_inc[POS_W-1];
                end
            end
            OP_READ:
            begin
                cmd.kind   = CMD_READ;
                cmd.status = ST_READ;
            end
            default:
            begin
                cmd.kind   = CMD_RESULT;
                cmd.status = ST_IGNORED;
            end
        endcase
        cmd.done = finished_next;
    end

    // counters; reset acts as a start with the reset weight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg    <= WEIGHT_RESET;
            sign_word_reg <= '0;
            sign_cnt_reg  <= '0;
            position_reg  <= POS_W'(COEFF_COUNT) - {{(POS_W-WEIGHT_W){1'b0}}, WEIGHT_RESET};
            finished_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                weight_reg <= cfg.weight;
            end
            if (fire)
            begin
                sign_word_reg <= sign_word_next;
                sign_cnt_reg  <= sign_cnt_next;
                position_reg  <= position_next;
                finished_reg  <= finished_next;
            end
        end
    end

endmodule

### rtl/scs_queue.sv
// ----------------------------------------------------------------------------
// scs_queue: command queue between front and back
// Small register FIFO of command words with valid/ready on both sides.
// ----------------------------------------------------------------------------
module scs_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  scs_pkg::cmd_t push_data,
    input  logic          push_valid,
    output logic          push_ready,
    output scs_pkg::cmd_t pop_data,
    output logic          pop_valid,
    input  logic          pop_ready
);
    import scs_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_Q = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_Q-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_Q'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_Q'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_Q'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/scs_back.sv
// ----------------------------------------------------------------------------
// scs_back: coefficient store and response stage
// Executes commands against the 256-entry store (one port, read-first),
// with a valid bit per entry so a start clears the store at once, and
// drives the registered response channel.
// ----------------------------------------------------------------------------
module scs_back (
    input  logic          clk,
    input  logic          rst_n,
    input  scs_pkg::cmd_t cmd,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    scs_rsp_if.source     rsp
);
    import scs_pkg::*;

    logic [1:0]             coeff_mem [COEFF_COUNT];
    logic [COEFF_COUNT-1:0] vld_reg;
    logic [1:0]             rd_data_reg;
    logic                   rd_vld_reg;

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] hold_pos_reg, hold_pos_next;
    logic [IDX_W-1:0] hold_b_reg, hold_b_next;
    logic             hold_done_reg, hold_done_next;

    logic              out_valid_reg, out_valid_next;
    logic        [2:0] out_status_reg, out_status_next;
    logic signed [1:0] out_coeff_reg, out_coeff_next;
    logic              out_done_reg, out_done_next;

    logic             slot_free;
    logic             mem_wr_en, mem_rd_en, clear_all;
    logic [IDX_W-1:0] mem_wr_addr, mem_rd_addr;
    logic [1:0]       mem_wr_data;

    assign slot_free       = !out_valid_reg || rsp.ready;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.coefficient = out_coeff_reg;
    assign rsp.done_res    = out_done_reg;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        hold_pos_next   = hold_pos_reg;
        hold_b_next     = hold_b_reg;
        hold_done_next  = hold_done_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_coeff_next  = out_coeff_reg;
        out_done_next   = out_done_reg;
        cmd_ready       = 1'b0;
        mem_wr_en       = 1'b0;
        mem_rd_en       = 1'b0;
        clear_all       = 1'b0;
        mem_wr_addr     = cmd.addr;
        mem_rd_addr     = cmd.addr;
        mem_wr_data     = cmd.sign ? COEFF_NEG : COEFF_POS;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && (slot_free || cmd.kind == CMD_READ))
                begin
                    cmd_ready     = 1'b1;
                    hold_pos_next = cmd.pos;
                    hold_b_next   = cmd.addr;
                    hold_done_next = cmd.done;
                    if (cmd.kind != CMD_READ)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = cmd.status;
                        out_coeff_next  = 2'sb00;
                        out_done_next   = cmd.done;
                    end
                    case (cmd.kind)
                        CMD_START:
                        begin
                            clear_all = 1'b1;
                        end
                        CMD_SWAP:
                        begin
                            // read old x[b] and write the sign into x[b]
                            mem_rd_en  = 1'b1;
                            mem_wr_en  = 1'b1;
                            state_next = BK_SWAP;
                        end
                        CMD_READ:
                        begin
                            mem_rd_en  = 1'b1;
                            state_next = BK_READ;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_SWAP:
            begin
                // old x[b] moves to x[i]; when i equals b the sign stays
                mem_wr_en   = (hold_pos_reg != hold_b_reg);
                mem_wr_addr = hold_pos_reg;
                mem_wr_data = rd_vld_reg ? rd_data_reg : COEFF_ZERO;
                state_next  = BK_IDLE;
            end
            BK_READ:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_READ;
                    out_coeff_next  = rd_vld_reg ? rd_data_reg : COEFF_ZERO;
                    out_done_next   = hold_done_reg;
                    state_next      = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (clear_all)
            begin
                vld_reg <= '0;
            end
            else if (mem_wr_en)
            begin
                vld_reg[mem_wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hold_pos_reg   <= hold_pos_next;
        hold_b_reg     <= hold_b_next;
        hold_done_reg  <= hold_done_next;
        out_status_reg <= out_status_next;
        out_coeff_reg  <= out_coeff_next;
        out_done_reg   <= out_done_next;
    end

    // coefficient store, read-first
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            coeff_mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rd_data_reg <= coeff_mem[mem_rd_addr];
            rd_vld_reg  <= vld_reg[mem_rd_addr];
        end
    end

endmodule

### rtl/sparse_challenge_sampler_top.sv
// ----------------------------------------------------------------------------
// sparse_challenge_sampler_top: sample-in-ball challenge builder
// Channel  Dir  Payload                              Word accepted when
// req      in   opcode, byte_value, read_index       req.valid && req.ready
// rsp      out  status, coefficient, done_res        rsp.valid && rsp.ready
// cfg      in   weight                               cfg.valid && cfg.ready
//
// The front takes one request word a cycle while req.ready is high into a
// queue of QUEUE_DEPTH words. Accepted indices and reads go on to BK_SWAP or
// BK_READ, set by the single store port (read-first swap, then the second
// write); other words finish in BK_IDLE. Reset acts as a start with weight 60,
// and a start clears the store at once through per-entry valid bits. A stalled
// response holds the back, which fills the queue and then drops req.ready.
// ----------------------------------------------------------------------------
module sparse_challenge_sampler_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      clk,
    input  logic      rst_n,
    scs_req_if.sink   req,
    scs_rsp_if.source rsp,
    scs_cfg_if.sink   cfg
);
    import scs_pkg::*;

    cmd_t front_cmd;
    logic front_valid, front_ready;
    cmd_t back_cmd;
    logic back_valid, back_ready;

    // decode and counters
    scs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    // command queue
    scs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_data   (back_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    // store and response
    scs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .rsp       (rsp)
    );

endmodule

### verif/tb_sparse_challenge_sampler_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sparse_challenge_sampler_top: self-checking bench of the challenge sampler
// Drives request words through a shared send task and predicts each response
// with a local sample-in-ball model. A free-running process checks every
// response word against the oldest prediction. Tests cover directed edge
// cases, weight extremes, a long response hold-off and random phases with
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_sparse_challenge_sampler_top;
    import scs_pkg::*;

    localparam logic [1:0] OP_NONE      = 2'd3;
    localparam int         CLK_HALF     = 5;
    localparam int         RESET_CYCLES = 10;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         PHASE_WORDS  = 350;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         MAX_REPORTS  = 40;
    localparam int         BYTE_GUARD   = 800;

    // one response word as predicted
    typedef struct packed {
        logic [2:0]        status;
        logic signed [1:0] coefficient;
        logic              done_res;
    } ball_rsp_t;

    logic clk = 1'b0;
    logic rst_n;

    scs_req_if req ();
    scs_rsp_if rsp ();
    scs_cfg_if cfg ();

    sparse_challenge_sampler_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #(CLK_HALF) clk = ~clk;

    // local copy of the sampler state
    logic [1:0]          ball_coeff [COEFF_COUNT];
    logic [SIGN_W-1:0]   ball_signs;
    logic [CNT_W-1:0]    ball_sign_cnt;
    logic [POS_W-1:0]    ball_pos;
    logic                ball_done;
    logic [WEIGHT_W-1:0] ball_weight;
    ball_rsp_t           ball_rsp_q [$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_left      = 0;
    logic hold_kick      = 1'b0;
    int   cycle_count    = 0;
    int   error_count    = 0;
    int   words_sent     = 0;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    // new challenge: clear store and counters, position from the weight
    function automatic void restart_ball();
        for (int k = 0; k < COEFF_COUNT; k++)
        begin
            ball_coeff[k] = COEFF_ZERO;
        end
        ball_signs    = '0;
        ball_sign_cnt = '0;
        ball_pos      = POS_W'(COEFF_COUNT) - POS_W'(ball_weight);
        ball_done     = ball_pos[POS_W-1];
    endfunction

    // response to one accepted request word, updating the local state
    function automatic ball_rsp_t sample_ball_step(input logic [1:0] op,
                                                   input logic [7:0] bv,
                                                   input logic [7:0] ri);
        ball_rsp_t r;
        r.status      = ST_IGNORED;
        r.coefficient = COEFF_ZERO;
        case (op)
            OP_START:
            begin
                restart_ball();
                r.status = ST_STARTED;
            end
            OP_BYTE:
            begin
                if (ball_done)
                begin
                    r.status = ST_IGNORED;
                end
                else if (ball_sign_cnt < CNT_W'(SIGN_BYTES))
                begin
                    // sign word fills least significant byte first
                    ball_signs    = ball_signs | (SIGN_W'(bv) << (8 * ball_sign_cnt));
                    ball_sign_cnt = ball_sign_cnt + CNT_W'(1);
                    r.status      = ST_SIGN;
                end
                else if (POS_W'(bv) > ball_pos)
                begin
                    r.status = ST_REJECT;
                end
                else
                begin
                    // swap: x[i] takes x[b], x[b] takes the signed one
                    ball_coeff[ball_pos[IDX_W-1:0]] = ball_coeff[bv];
                    ball_coeff[bv] = ball_signs[0] ? COEFF_NEG : COEFF_POS;
                    ball_signs     = ball_signs >> 1;
                    ball_pos       = ball_pos + POS_W'(1);
                    if (ball_pos == POS_W'(COEFF_COUNT))
                    begin
                        ball_done = 1'b1;
                    end
                    r.status = ST_ACCEPT;
                end
            end
            OP_READ:
            begin
                r.coefficient = ball_coeff[ri];
                r.status      = ST_READ;
            end
            default:
            begin
                r.status = ST_IGNORED;
            end
        endcase
        r.done_res = ball_done;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // response side: stalls, hold-off and checking
    // ------------------------------------------------------------------------

    // long hold-off, loaded on a kick and counted down here
    always @(posedge clk)
    begin
        if (hold_kick)
        begin
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    task automatic report_field(input string name, input logic signed [3:0] want,
                                input logic signed [3:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : rsp_check
        ball_rsp_t want;
        if (rst_n === 1'b1 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
        begin
            if (ball_rsp_q.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                begin
                    $display("%0t: unexpected response word, expected none, actual %0d/%0d/%0d",
                             $time, rsp.status, rsp.coefficient, rsp.done_res);
                end
            end
            else
            begin
                want = ball_rsp_q.pop_front();
                if (rsp.status !== want.status)
                begin
                    report_field("status", 4'(want.status), 4'(rsp.status));
                end
                if (rsp.coefficient !== want.coefficient)
                begin
                    report_field("coefficient", 4'(want.coefficient), 4'(rsp.coefficient));
                end
                if (rsp.done_res !== want.done_res)
                begin
                    report_field("done_res", 4'(want.done_res), 4'(rsp.done_res));
                end
            end
        end
        rsp.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // request side helpers
    // ------------------------------------------------------------------------

    function automatic logic [7:0] rand8();
        return 8'($urandom_range(0, 255));
    endfunction

    // offer one request word, predict its response once accepted
    task automatic send_word(input logic [1:0] op, input logic [7:0] bv,
                             input logic [7:0] ri);
        ball_rsp_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.opcode     <= op;
        req.byte_value <= bv;
        req.read_index <= ri;
        do @(posedge clk); while (req.ready !== 1'b1);
        r = sample_ball_step(op, bv, ri);
        ball_rsp_q.push_back(r);
        words_sent++;
    endtask

    // sender goes quiet until every response is in, then settles
    task automatic wait_drained();
        req.valid <= 1'b0;
        while (ball_rsp_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_weight(input logic [WEIGHT_W-1:0] w);
        wait_drained();
        cfg.valid  <= 1'b1;
        cfg.weight <= w;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        cfg.valid   <= 1'b0;
        ball_weight  = w;
    endtask

    function automatic logic [WEIGHT_W-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return 7'd0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'd127;
            4:       return 7'($urandom_range(0, 127));
            default: return 7'($urandom_range(1, 64));
        endcase
    endfunction

    // well-formed challenge: start, sign word, indices and reads until done, stray bytes, reads
    task automatic run_challenge();
        int guard;
        logic [7:0] ri;
        guard = 0;
        send_word(OP_START, rand8(), rand8());
        repeat (SIGN_BYTES) send_word(OP_BYTE, rand8(), rand8());
        while (!ball_done && guard < BYTE_GUARD)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_word(OP_READ, rand8(), rand8());
            end
            else
            begin
                send_word(OP_BYTE, rand8(), rand8());
            end
            guard++;
        end
        repeat ($urandom_range(0, 3)) send_word(OP_BYTE, rand8(), rand8());
        repeat ($urandom_range(2, 8))
        begin
            // lean towards the top end, where the ones land
            ri = $urandom_range(0, 1) ? rand8() : 8'($urandom_range(192, 255));
            send_word(OP_READ, rand8(), ri);
        end
    endtask

    // broken prefixes and random words of any opcode
    task automatic run_noise();
        if ($urandom_range(0, 1))
        begin
            send_word(OP_START, rand8(), rand8());
            repeat ($urandom_range(0, 12)) send_word(OP_BYTE, rand8(), rand8());
        end
        repeat ($urandom_range(1, 12)) send_word(2'($urandom_range(0, 3)), rand8(), rand8());
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset acts as a start with weight 60, so bytes go straight in
    task automatic test_directed_basics();
        send_word(OP_READ, 8'h00, 8'h00);
        send_word(OP_READ, 8'hFF, 8'hFF);
        send_word(OP_NONE, 8'hFF, 8'hFF);
        send_word(OP_BYTE, 8'hFF, 8'h00);
        send_word(OP_BYTE, 8'h00, 8'hFF);
        send_word(OP_BYTE, 8'h5A, 8'h00);
        send_word(OP_BYTE, 8'hA5, 8'h00);
        send_word(OP_BYTE, 8'h00, 8'h00);
        send_word(OP_BYTE, 8'h00, 8'h00);
        send_word(OP_BYTE, 8'h00, 8'h00);
        send_word(OP_BYTE, 8'h80, 8'h00);
        // index above position, equal to it, zero, then just below
        send_word(OP_BYTE, 8'hFF, 8'h00);
        send_word(OP_BYTE, 8'd196, 8'h00);
        send_word(OP_BYTE, 8'h00, 8'h00);
        send_word(OP_BYTE, 8'd197, 8'h00);
        send_word(OP_READ, 8'h00, 8'd0);
        send_word(OP_READ, 8'h00, 8'd196);
        send_word(OP_READ, 8'h00, 8'd197);
        send_word(OP_READ, 8'h00, 8'd198);
        send_word(OP_START, 8'hFF, 8'hFF);
        send_word(OP_READ, 8'h00, 8'd0);
    endtask

    task automatic test_weight_extremes();
        // weight zero: done at once, bytes ignored
        write_weight(7'd0);
        send_word(OP_START, 8'h00, 8'h00);
        send_word(OP_BYTE, 8'h00, 8'h00);
        send_word(OP_READ, 8'h00, 8'h00);
        // new weight waits for the next start
        write_weight(7'd1);
        send_word(OP_BYTE, 8'hFF, 8'h00);
        send_word(OP_START, 8'h00, 8'h00);
        repeat (SIGN_BYTES) send_word(OP_BYTE, 8'h01, 8'h00);
        send_word(OP_BYTE, 8'hFF, 8'h00);
        send_word(OP_BYTE, 8'h00, 8'h00);
        send_word(OP_READ, 8'h00, 8'hFF);
        // beyond the sign word, placements fall back to +1
        write_weight(7'd127);
        run_challenge();
        write_weight(7'd64);
        run_challenge();
    endtask

    // receiver holds off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_kick     <= 1'b1;
        @(posedge clk);
        hold_kick     <= 1'b0;
        run_challenge();
        wait_drained();
        run_challenge();
        wait_drained();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input int count);
        int target;
        target         = words_sent + count;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        write_weight(pick_weight());
        while (words_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                write_weight(pick_weight());
            end
            if ($urandom_range(0, 99) < 85)
            begin
                run_challenge();
            end
            else
            begin
                run_noise();
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.opcode     <= OP_START;
        req.byte_value <= 8'h00;
        req.read_index <= 8'h00;
        cfg.valid      <= 1'b0;
        cfg.weight     <= WEIGHT_RESET;
        ball_weight     = WEIGHT_RESET;
        restart_ball();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_weight_extremes();
        test_backpressure();
        test_random_phase(0, 0, PHASE_WORDS);
        test_random_phase(57, 0, PHASE_WORDS);
        test_random_phase(0, 57, PHASE_WORDS);
        test_random_phase(16, 16, PHASE_WORDS);
        wait_drained();

        if (error_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
